@@ src/pic_pkg.sv @@
// shared constants and types for the point in convex polygon tester
package pic_pkg;

   localparam int MAX_VERTICES_DEF = 16;
   localparam int COORD_BITS_DEF   = 16;

   localparam int VCOUNT_W = 5;
   localparam int INDEX_W  = 4;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd4;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_TEST  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

endpackage

@@ src/point_in_convex_polygon.sv @@
// point in convex polygon tester: vertex store, edge walker and cross product unit
//
// Input items enter on start/busy: an item is taken at a clock edge with start high and
// busy low. req_action selects a vertex write or a point test. A vertex write goes into
// the store in the accept cycle and gives no result; busy stays low. A point test with
// an effective vertex count n of two or more raises busy and walks the store one vertex
// per cycle through a shared edge-difference, cross product and compare pipeline; the
// single result strobes on rsp_valid with rsp_inside_res, and busy drops in that cycle.
// The vertex store read port, one read per cycle, sets the rate of the walk.
// A test with n of zero or one strobes inside in the cycle after the accept, busy low.
// The vertex count register is written on the csr channel (csr_valid and csr_ready),
// always ready; the user must write it only while no test is running, which the block
// itself does not enforce. Counts above the store size act as the store size.
// Reset is synchronous: the count returns to four, any running test is dropped and no
// strobe follows. The vertex store is not cleared. Results are one-cycle strobes that
// the receiver must take; it cannot stall the block.
module point_in_convex_polygon #(
   parameter int MAX_VERTICES = pic_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = pic_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [pic_pkg::INDEX_W-1:0]   req_vertex_index,
   input  logic signed [COORD_BITS-1:0]  req_coord_x,
   input  logic signed [COORD_BITS-1:0]  req_coord_y,
   output logic                          rsp_valid,
   output logic                          rsp_inside_res,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pic_pkg::VCOUNT_W-1:0]  csr_vertex_count
);

   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int CW     = (CNT_W > pic_pkg::VCOUNT_W) ? CNT_W : pic_pkg::VCOUNT_W;
   localparam int D_W    = COORD_BITS + 1;
   localparam int PROD_W = 2 * D_W;

   pic_pkg::state_type state_ff, state_in;

   logic [pic_pkg::VCOUNT_W-1:0] vertex_count_ff, vertex_count_in;
   logic [CNT_W-1:0]             n_ff, n_in, iss_ff, iss_in;
   logic [CW-1:0]                cnt_wide;
   logic [CNT_W-1:0]             n_eff;
   logic signed [COORD_BITS-1:0] pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;

   logic accept, accept_test, accept_write, idx_ok;
   logic [31:0] idx_wide;

   logic                   ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]      ram_wr_addr, ram_rd_addr;
   logic [2*COORD_BITS-1:0] ram_wr_data, ram_rd_data;

   // issue tags and their copies one stage on
   logic t0_vld, t0_wrap, t0_zero, t0_fe;
   logic t1_vld_ff, t1_wrap_ff, t1_zero_ff, t1_fe_ff;
   logic t2_vld_ff, t2_last_ff, t2_fe_ff;
   logic t3_vld_ff, t3_last_ff, t3_fe_ff;

   logic signed [COORD_BITS-1:0] v0_x_ff, v0_x_in, v0_y_ff, v0_y_in;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [COORD_BITS-1:0] rd_x, rd_y, cur_x, cur_y;

   logic signed [D_W-1:0] ex_ff, ex_in, ey_ff, ey_in, dx_ff, dx_in, dy_ff, dy_in;
   logic signed [PROD_W-1:0] p1_ff, p1_in, p2_ff, p2_in;

   logic pos, first_ff, first_in, bad_ff, bad_in, mismatch;
   logic rsp_valid_ff, rsp_valid_in, rsp_inside_ff, rsp_inside_in;

   assign busy      = (state_ff != pic_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   assign accept       = start && !busy;
   assign accept_test  = accept && (req_action == pic_pkg::ACT_TEST);
   assign accept_write = accept && (req_action == pic_pkg::ACT_WRITE);

   assign idx_wide    = 32'(req_vertex_index);
   assign idx_ok      = (idx_wide < 32'(MAX_VERTICES));
   assign ram_wr_en   = accept_write && idx_ok;
   assign ram_wr_addr = idx_wide[ADDR_W-1:0];
   assign ram_wr_data = {req_coord_x, req_coord_y};

   // count saturates at the store size
   assign cnt_wide = CW'(vertex_count_ff);
   assign n_eff    = (cnt_wide > CW'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(cnt_wide);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      iss_in      = iss_ff;
      n_in        = n_ff;
      pt_x_in     = pt_x_ff;
      pt_y_in     = pt_y_ff;
      t0_vld      = 1'b0;
      t0_wrap     = 1'b0;
      t0_zero     = 1'b0;
      t0_fe       = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = iss_ff[ADDR_W-1:0];
      case (state_ff)
         pic_pkg::ST_IDLE: begin
            if (accept_test && (n_eff > CNT_W'(1))) begin
               state_in = pic_pkg::ST_ISSUE;
               iss_in   = '0;
               n_in     = n_eff;
               pt_x_in  = req_coord_x;
               pt_y_in  = req_coord_y;
            end
         end
         pic_pkg::ST_ISSUE: begin
            t0_vld = 1'b1;
            if (iss_ff == n_ff) begin
               t0_wrap  = 1'b1;
               state_in = pic_pkg::ST_DRAIN;
            end else begin
               ram_rd_en = 1'b1;
               t0_zero   = (iss_ff == '0);
               t0_fe     = (iss_ff == CNT_W'(1));
               iss_in    = iss_ff + CNT_W'(1);
            end
         end
         pic_pkg::ST_DRAIN: begin
            if (t3_vld_ff && t3_last_ff) begin
               state_in = pic_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pic_pkg::ST_IDLE;
         end
      endcase
   end

   pic_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // edge differences
   assign rd_x  = $signed(ram_rd_data[2*COORD_BITS-1:COORD_BITS]);
   assign rd_y  = $signed(ram_rd_data[COORD_BITS-1:0]);
   assign cur_x = t1_wrap_ff ? v0_x_ff : rd_x;
   assign cur_y = t1_wrap_ff ? v0_y_ff : rd_y;

   always_comb begin
      v0_x_in   = v0_x_ff;
      v0_y_in   = v0_y_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      if (t1_vld_ff && t1_zero_ff) begin
         v0_x_in = rd_x;
         v0_y_in = rd_y;
      end
      if (t1_vld_ff) begin
         prev_x_in = cur_x;
         prev_y_in = cur_y;
      end
      ex_in = D_W'(cur_x) - D_W'(prev_x_ff);
      ey_in = D_W'(cur_y) - D_W'(prev_y_ff);
      dx_in = D_W'(pt_x_ff) - D_W'(prev_x_ff);
      dy_in = D_W'(pt_y_ff) - D_W'(prev_y_ff);
   end

   // cross product terms
   assign p1_in = PROD_W'(ex_ff) * PROD_W'(dy_ff);
   assign p2_in = PROD_W'(dx_ff) * PROD_W'(ey_ff);

   // sign agreement
   assign pos      = (p1_ff > p2_ff);
   assign mismatch = !t3_fe_ff && (pos != first_ff);

   always_comb begin
      first_in      = first_ff;
      bad_in        = bad_ff;
      rsp_valid_in  = 1'b0;
      rsp_inside_in = rsp_inside_ff;
      if (t3_vld_ff) begin
         if (t3_fe_ff) begin
            first_in = pos;
            bad_in   = 1'b0;
         end else if (mismatch) begin
            bad_in = 1'b1;
         end
         if (t3_last_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_inside_in = !(bad_ff || mismatch);
         end
      end
      if (accept_test && (n_eff <= CNT_W'(1))) begin
         rsp_valid_in  = 1'b1;
         rsp_inside_in = 1'b1;
      end
   end

   assign vertex_count_in = (csr_valid && csr_ready) ? csr_vertex_count : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pic_pkg::ST_IDLE;
         vertex_count_ff <= pic_pkg::VCOUNT_RESET;
         t1_vld_ff       <= 1'b0;
         t2_vld_ff       <= 1'b0;
         t3_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         vertex_count_ff <= vertex_count_in;
         t1_vld_ff       <= t0_vld;
         t2_vld_ff       <= t1_vld_ff && !t1_zero_ff;
         t3_vld_ff       <= t2_vld_ff;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff        <= iss_in;
      n_ff          <= n_in;
      pt_x_ff       <= pt_x_in;
      pt_y_ff       <= pt_y_in;
      t1_wrap_ff    <= t0_wrap;
      t1_zero_ff    <= t0_zero;
      t1_fe_ff      <= t0_fe;
      t2_last_ff    <= t1_wrap_ff;
      t2_fe_ff      <= t1_fe_ff;
      t3_last_ff    <= t2_last_ff;
      t3_fe_ff      <= t2_fe_ff;
      v0_x_ff       <= v0_x_in;
      v0_y_ff       <= v0_y_in;
      prev_x_ff     <= prev_x_in;
      prev_y_ff     <= prev_y_in;
      ex_ff         <= ex_in;
      ey_ff         <= ey_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      first_ff      <= first_in;
      bad_ff        <= bad_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

`ifndef SYNTHESIS
   a_test_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept_test && (n_eff > CNT_W'(1))) |=> busy)
      else $error("test item with several vertices did not start a walk");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pic_pkg::ST_ISSUE) |-> (iss_ff <= n_ff))
      else $error("vertex walk ran past the vertex count");

   a_last_edge_in_drain: assert property (@(posedge clock) disable iff (reset)
      (t3_vld_ff && t3_last_ff) |-> (state_ff == pic_pkg::ST_DRAIN))
      else $error("closing edge seen outside the drain state");
`endif

endmodule

@@ src/pic_ram.sv @@
// generic single write, single read ram with registered read data
module pic_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/tb_point_in_convex_polygon.sv @@
// testbench for point_in_convex_polygon: vertex writes, point tests and count changes checked
`timescale 1ns / 1ps

class inside_checker;
   logic signed [15:0] vert_x [pic_pkg::MAX_VERTICES_DEF];
   logic signed [15:0] vert_y [pic_pkg::MAX_VERTICES_DEF];
   logic [pic_pkg::VCOUNT_W-1:0] vertex_count;
   bit pending_inside [$];
   int mismatches;

   function new();
      vertex_count = pic_pkg::VCOUNT_RESET;
      mismatches = 0;
      foreach (vert_x[k]) begin
         vert_x[k] = '0;
         vert_y[k] = '0;
      end
   endfunction

   function void set_count(logic [pic_pkg::VCOUNT_W-1:0] value);
      vertex_count = value;
   endfunction

   function bit predict_inside(logic signed [15:0] px, logic signed [15:0] py);
      int n;
      int j;
      longint ex, ey, dx, dy;
      bit pos;
      bit first_pos;
      n = (vertex_count > pic_pkg::MAX_VERTICES_DEF) ? pic_pkg::MAX_VERTICES_DEF
                                                      : int'(vertex_count);
      first_pos = 1'b0;
      for (int i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         ex = longint'(vert_x[j]) - longint'(vert_x[i]);
         ey = longint'(vert_y[j]) - longint'(vert_y[i]);
         dx = longint'(px) - longint'(vert_x[i]);
         dy = longint'(py) - longint'(vert_y[i]);
         pos = (ex * dy - dx * ey) > 0;
         if (i == 0) begin
            first_pos = pos;
         end else if (pos != first_pos) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function void note_item(logic action, logic [pic_pkg::INDEX_W-1:0] slot,
                           logic signed [15:0] x, logic signed [15:0] y);
      if (action == pic_pkg::ACT_WRITE) begin
         vert_x[slot] = x;
         vert_y[slot] = y;
      end else begin
         pending_inside.push_back(predict_inside(x, y));
      end
   endfunction

   function void check_inside(logic got);
      bit want;
      if (pending_inside.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result with no test pending, inside_res %0b", $time, got);
      end else begin
         want = pending_inside.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: inside_res mismatch, expected %0b got %0b", $time, want, got);
         end
      end
   endfunction
endclass

module tb_point_in_convex_polygon;

   localparam int ITEM_TARGET = 750;
   localparam int LAST_PART   = 650;
   localparam int DRAIN_PAUSE = 25;
   localparam int QUIET_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic req_action = pic_pkg::ACT_WRITE;
   logic [pic_pkg::INDEX_W-1:0] req_vertex_index = '0;
   logic signed [15:0] req_coord_x = '0;
   logic signed [15:0] req_coord_y = '0;
   logic csr_valid = 1'b0;
   logic [pic_pkg::VCOUNT_W-1:0] csr_vertex_count = '0;
   logic busy;
   logic rsp_valid;
   logic rsp_inside_res;
   logic csr_ready;

   inside_checker sb;
   int items_sent = 0;
   int quiet_cycles = 0;
   bit idle_enabled = 1'b1;
   logic signed [15:0] shape_x [pic_pkg::MAX_VERTICES_DEF];
   logic signed [15:0] shape_y [pic_pkg::MAX_VERTICES_DEF];
   int center_x = 0;
   int center_y = 0;
   int radius = 1;

   point_in_convex_polygon dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_inside_res   (rsp_inside_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_vertex_count (csr_vertex_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_inside(rsp_inside_res);
         if (start && !busy)
            sb.note_item(req_action, req_vertex_index, req_coord_x, req_coord_y);
         if (csr_valid && csr_ready)
            sb.set_count(csr_vertex_count);
         quiet_cycles <= (rsp_valid || (start && !busy) || (csr_valid && csr_ready))
                         ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic signed [15:0] clamp_coord(int v);
      if (v > 32767)
         return 16'h7FFF;
      if (v < -32768)
         return 16'h8000;
      return v[15:0];
   endfunction

   task automatic send_item(input logic action, input logic [pic_pkg::INDEX_W-1:0] slot,
                            input logic signed [15:0] x, input logic signed [15:0] y);
      if (idle_enabled && items_sent < LAST_PART && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= action;
      req_vertex_index <= slot;
      req_coord_x <= x;
      req_coord_y <= y;
      if (action == pic_pkg::ACT_WRITE) begin
         shape_x[slot] = x;
         shape_y[slot] = y;
      end
      items_sent++;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_block();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_inside.size() != 0)
         @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_count(input logic [pic_pkg::VCOUNT_W-1:0] value);
      repeat ($urandom_range(0, 3)) @(posedge clock);
      csr_vertex_count <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // convex polygon around a random center or the origin, either winding; now and then plain noise
   task automatic build_shape(int n);
      int kind;
      bit broken;
      real first_angle, step_angle, ang;
      kind = $urandom_range(0, 3);
      case (kind)
         0: radius = $urandom_range(1, 40);
         3: radius = $urandom_range(10000, 32767);
         default: radius = $urandom_range(100, 8000);
      endcase
      center_x = (kind == 3) ? 0 : int'($urandom_range(0, 40000)) - 20000;
      center_y = (kind == 3) ? 0 : int'($urandom_range(0, 40000)) - 20000;
      step_angle = 6.283185307179586 / n;
      if ($urandom_range(0, 1) == 0)
         step_angle = -step_angle;
      first_angle = $urandom_range(0, 359) * 3.141592653589793 / 180.0;
      broken = $urandom_range(0, 6) == 0;
      for (int k = 0; k < n; k++) begin
         if (broken) begin
            send_item(pic_pkg::ACT_WRITE, 4'(k), 16'($urandom), 16'($urandom));
         end else begin
            ang = first_angle + k * step_angle;
            send_item(pic_pkg::ACT_WRITE, 4'(k),
                      clamp_coord(center_x + int'(radius * $cos(ang))),
                      clamp_coord(center_y + int'(radius * $sin(ang))));
         end
      end
   endtask

   task automatic test_some_point(int n);
      int sel, k, j, span, px, py, lo_x, hi_x, lo_y, hi_y;
      sel = $urandom_range(0, 9);
      k = $urandom_range(0, n - 1);
      j = (k + 1) % n;
      case (sel)
         0: begin
            px = center_x;
            py = center_y;
         end
         1, 2, 3: begin
            span = radius / 2 + 1;
            px = center_x + int'($urandom_range(2 * span, 0)) - span;
            py = center_y + int'($urandom_range(2 * span, 0)) - span;
         end
         4: begin
            px = shape_x[k];
            py = shape_y[k];
         end
         5: begin
            px = (int'(shape_x[k]) + int'(shape_x[j])) / 2;
            py = (int'(shape_y[k]) + int'(shape_y[j])) / 2;
         end
         6, 7: begin
            lo_x = 32767;
            hi_x = -32768;
            lo_y = 32767;
            hi_y = -32768;
            for (int m = 0; m < n; m++) begin
               if (shape_x[m] < lo_x) lo_x = shape_x[m];
               if (shape_x[m] > hi_x) hi_x = shape_x[m];
               if (shape_y[m] < lo_y) lo_y = shape_y[m];
               if (shape_y[m] > hi_y) hi_y = shape_y[m];
            end
            px = lo_x + int'($urandom_range(hi_x - lo_x, 0));
            py = lo_y + int'($urandom_range(hi_y - lo_y, 0));
         end
         8: begin
            px = int'($urandom_range(65535, 0)) - 32768;
            py = int'($urandom_range(65535, 0)) - 32768;
         end
         default: begin
            px = $urandom_range(0, 1) ? 32767 : -32768;
            py = $urandom_range(0, 1) ? 32767 : -32768;
         end
      endcase
      send_item(pic_pkg::ACT_TEST, 4'($urandom), clamp_coord(px), clamp_coord(py));
   endtask

   initial begin
      int count_value;
      int n_eff;
      int phase_no;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // full-range square, counter-clockwise, tested at the reset count
      send_item(pic_pkg::ACT_WRITE, 4'd0, 16'sh8000, 16'sh8000);
      send_item(pic_pkg::ACT_WRITE, 4'd1, 16'sh7FFF, 16'sh8000);
      send_item(pic_pkg::ACT_WRITE, 4'd2, 16'sh7FFF, 16'sh7FFF);
      send_item(pic_pkg::ACT_WRITE, 4'd3, 16'sh8000, 16'sh7FFF);
      send_item(pic_pkg::ACT_TEST, 4'd0, 16'sd0, 16'sd0);
      send_item(pic_pkg::ACT_TEST, 4'd15, 16'sh8000, 16'sh8000);
      send_item(pic_pkg::ACT_TEST, 4'd5, 16'sd0, 16'sh8000);
      send_item(pic_pkg::ACT_TEST, 4'd10, 16'sh7FFF, -16'sd1);
      // degenerate counts
      drain_block();
      write_count(5'd0);
      send_item(pic_pkg::ACT_TEST, 4'd3, 16'sh7FFF, 16'sh8000);
      drain_block();
      write_count(5'd1);
      send_item(pic_pkg::ACT_TEST, 4'd12, -16'sd1, -16'sd1);
      drain_block();
      write_count(5'd2);
      send_item(pic_pkg::ACT_TEST, 4'd6, 16'sd0, 16'sd0);
      // triangle from the first three corners
      drain_block();
      write_count(5'd3);
      send_item(pic_pkg::ACT_TEST, 4'd9, 16'sd16000, -16'sd16000);
      send_item(pic_pkg::ACT_TEST, 4'd9, -16'sd16000, 16'sd16000);

      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         drain_block();
         case (phase_no)
            0: count_value = 31;
            1: count_value = 16;
            default: begin
               case ($urandom_range(0, 9))
                  0: count_value = $urandom_range(0, 2);
                  1: count_value = $urandom_range(16, 31);
                  default: count_value = $urandom_range(3, 16);
               endcase
            end
         endcase
         write_count(5'(count_value));
         n_eff = (count_value > pic_pkg::MAX_VERTICES_DEF) ? pic_pkg::MAX_VERTICES_DEF
                                                          : count_value;
         if (n_eff < 1)
            n_eff = 1;
         idle_enabled = $urandom_range(0, 3) != 0;
         build_shape(n_eff);
         repeat ($urandom_range(8, 30)) begin
            if ($urandom_range(0, 9) == 0)
               send_item(pic_pkg::ACT_WRITE, 4'($urandom), 16'($urandom), 16'($urandom));
            else
               test_some_point(n_eff);
         end
         phase_no++;
      end
      drain_block();
      if (sb.mismatches == 0 && sb.pending_inside.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
